FILE: rtl/assert_macros.svh
// assertion macros used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under an active-low reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication under an active-low reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/hvn_pkg.sv
// shared widths, register indexes and a helper for the heightfield normal block
package hvn_pkg;

    localparam int HEIGHT_W    = 16;
    localparam int SCALE_W     = 16;
    localparam int GRID_CFG_W  = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int NX_W        = 16;
    localparam int NY_W        = 15;
    localparam int NZ_W        = 16;
    localparam int POS_OUT_W   = 10;
    localparam int OUT_DATA_W  = 72;
    localparam int UNIT_ONE    = 16384;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_SCALE = 2'd2;

    // remainder by three through a reciprocal multiply
    function automatic logic [1:0] mod3(input logic [15:0] v);
        logic [32:0] p;
        logic [15:0] q;
        logic [17:0] t;
        p = 33'(v) * 33'(43691);
        q = p[32:17];
        t = 18'(v) - 18'(q) * 18'd3;
        return t[1:0];
    endfunction

endpackage

FILE: rtl/heightfield_vertex_normals.sv
// heightfield vertex normal engine: line stores, neighborhood sums, exact unit normalization
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------------------
//  s       | s_tvalid/s_tready  | s_tdata: height; s_tuser: cmd (1 = drain)
//  m       | m_tvalid/m_tready  | m_tdata: normal_x, normal_y, normal_z, row, col; m_tlast
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data (always ready)
//
// an item is taken while the engine is idle; each normal it causes then runs the
// window reads through the single read port, 9 steps of the shared multiplier,
// and a bit-serial square root compare for x, y and z, one result bit per add
// and compare pair; a sample item causes 0, 1 or 2 normals, a drain item 0 or 1
// reset clears control state only; the line stores hold garbage until written
// a finished normal waits in the output register while the next item is taken or the next
// normal computed; a new normal waits in ST_OUT until that register is free or being taken
module heightfield_vertex_normals
    import hvn_pkg::*;
#(
    parameter int MAX_GRID = 1024
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [HEIGHT_W-1:0]    s_tdata,    // height
    input  logic                   s_tuser,    // cmd
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,    // normal_x, normal_y, normal_z, vertex_row,
                                               // vertex_col, zero fill
    output logic                   m_tlast,    // frame_last
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int PW        = $clog2(MAX_GRID);
    localparam int DW        = PW + 1;
    localparam int AW        = PW + 2;
    localparam int MEM_DEPTH = 3 * (2 ** PW);
    localparam int SUM_W     = 20;
    localparam int WW        = 108;

    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_MUL,
        ST_SEARCH_INIT,
        ST_SEARCH_ADD,
        ST_SEARCH_CMP,
        ST_OUT
    } state_t;

    state_t                  state_reg;
    logic [GRID_CFG_W-1:0]   grid_cols_reg;
    logic [GRID_CFG_W-1:0]   grid_rows_reg;
    logic [SCALE_W-1:0]      height_scale_reg;
    logic [PW-1:0]           row_pos_reg;
    logic [PW-1:0]           col_pos_reg;
    logic [PW-1:0]           drain_pos_reg;
    logic                    draining_reg;
    logic [PW-1:0]           vr_reg;
    logic [PW-1:0]           vc_reg;
    logic                    second_reg;
    logic                    last_reg;
    logic [3:0]              rd_cnt_reg;
    logic [1:0]              ri_reg;
    logic [1:0]              ci_reg;
    logic [3:0]              mul_step_reg;
    logic [1:0]              comp_reg;
    logic [3:0]              bit_reg;
    logic                    m_tvalid_reg;
    logic                    m_tlast_reg;

    logic [HEIGHT_W-1:0]     mem [0:MEM_DEPTH-1];
    logic [HEIGHT_W-1:0]     rd_data_reg;
    logic signed [SUM_W-1:0] win_reg [0:8];
    logic signed [SUM_W-1:0] sx_reg;
    logic signed [SUM_W-1:0] sz_reg;
    logic [2:0]              n_reg;
    logic [51:0]             prod_reg;
    logic [31:0]             sc2_reg;
    logic [37:0]             sx2_reg;
    logic [37:0]             sz2_reg;
    logic [69:0]             xq_reg;
    logic [69:0]             zq_reg;
    logic [71:0]             l2_reg;
    logic signed [WW-1:0]    f_reg;
    logic signed [WW-1:0]    g_reg;
    logic signed [WW-1:0]    ls_reg;
    logic signed [WW-1:0]    tmp_reg;
    logic signed [WW-1:0]    gacc_reg;
    logic [NY_W-1:0]         m_reg;
    logic [NY_W-1:0]         kx_reg;
    logic [NY_W-1:0]         ky_reg;
    logic [NY_W-1:0]         kz_reg;
    logic [OUT_DATA_W-1:0]   m_tdata_reg;

    logic [DW-1:0]           cols_c;
    logic [DW-1:0]           rows_c;
    logic                    col_end;
    logic                    row_end;
    logic                    drain_end;
    logic                    mem_we;
    logic [AW-1:0]           wr_addr;
    logic [AW-1:0]           rd_addr;
    logic [DW-1:0]           rd_row;
    logic [PW-1:0]           rd_col;
    logic                    up_ok;
    logic                    dn_ok;
    logic                    lf_ok;
    logic                    rt_ok;
    logic signed [SUM_W-1:0] sx_c;
    logic signed [SUM_W-1:0] sz_c;
    logic [2:0]              n_c;
    logic [SUM_W-1:0]        ax_c;
    logic [SUM_W-1:0]        az_c;
    logic [5:0]              nsq;
    logic [19:0]             mul_a;
    logic [31:0]             mul_b;
    logic [51:0]             mul_p;
    logic signed [WW-1:0]    r_sel;
    logic signed [WW-1:0]    cand;
    logic                    acc;
    logic [NY_W-1:0]         k_c;
    logic                    out_load;
    logic [NX_W-1:0]         nx_c;
    logic [NY_W-1:0]         ny_c;
    logic [NZ_W-1:0]         nz_c;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tlast   = m_tlast_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb
    begin
        if (grid_cols_reg < GRID_CFG_W'(2))
            cols_c = DW'(2);
        else if (32'(grid_cols_reg) > MAX_GRID)
            cols_c = DW'(MAX_GRID);
        else
            cols_c = DW'(grid_cols_reg);
        if (grid_rows_reg < GRID_CFG_W'(2))
            rows_c = DW'(2);
        else if (32'(grid_rows_reg) > MAX_GRID)
            rows_c = DW'(MAX_GRID);
        else
            rows_c = DW'(grid_rows_reg);
    end

    assign col_end   = (DW'(col_pos_reg) + DW'(1)) >= cols_c;
    assign row_end   = (DW'(row_pos_reg) + DW'(1)) >= rows_c;
    assign drain_end = (DW'(drain_pos_reg) + DW'(1)) >= cols_c;

    // line store: one write port for samples, one registered read port for the window
    assign mem_we  = s_tvalid && s_tready && !s_tuser && !draining_reg;
    assign wr_addr = {mod3(16'(row_pos_reg)), col_pos_reg};
    assign rd_row  = DW'(vr_reg) + DW'(ri_reg) - DW'(1);
    assign rd_col  = vc_reg + PW'(ci_reg) - PW'(1);
    assign rd_addr = {mod3(16'(rd_row)), rd_col};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= s_tdata;
        rd_data_reg <= mem[rd_addr];
    end

    // cells around the vertex that lie inside the grid
    assign up_ok = (vr_reg != '0) && (DW'(vr_reg) < rows_c);
    assign dn_ok = (DW'(vr_reg) + DW'(1)) < rows_c;
    assign lf_ok = (vc_reg != '0) && (DW'(vc_reg) < cols_c);
    assign rt_ok = (DW'(vc_reg) + DW'(1)) < cols_c;

    always_comb
    begin
        sx_c = '0;
        sz_c = '0;
        n_c  = '0;
        if (dn_ok && rt_ok)
        begin
            sx_c = sx_c + (win_reg[4] - win_reg[5]) + (win_reg[7] - win_reg[8]);
            sz_c = sz_c + (win_reg[8] - win_reg[5]) + (win_reg[7] - win_reg[4]);
            n_c  = n_c + 3'd2;
        end
        if (dn_ok && lf_ok)
        begin
            sx_c = sx_c + (win_reg[3] - win_reg[4]);
            sz_c = sz_c + (win_reg[7] - win_reg[4]);
            n_c  = n_c + 3'd1;
        end
        if (up_ok && lf_ok)
        begin
            sx_c = sx_c + (win_reg[0] - win_reg[1]) + (win_reg[3] - win_reg[4]);
            sz_c = sz_c + (win_reg[4] - win_reg[1]) + (win_reg[3] - win_reg[0]);
            n_c  = n_c + 3'd2;
        end
        if (up_ok && rt_ok)
        begin
            sx_c = sx_c + (win_reg[4] - win_reg[5]);
            sz_c = sz_c + (win_reg[4] - win_reg[1]);
            n_c  = n_c + 3'd1;
        end
    end

    assign ax_c = sx_reg[SUM_W-1] ? SUM_W'(-sx_reg) : SUM_W'(sx_reg);
    assign az_c = sz_reg[SUM_W-1] ? SUM_W'(-sz_reg) : SUM_W'(sz_reg);
    assign nsq  = 6'(n_reg) * 6'(n_reg);

    // shared multiplier schedule
    always_comb
    begin
        unique case (mul_step_reg)
            4'd0:
            begin
                mul_a = 20'(height_scale_reg);
                mul_b = 32'(height_scale_reg);
            end
            4'd1:
            begin
                mul_a = ax_c;
                mul_b = 32'(ax_c);
            end
            4'd2:
            begin
                mul_a = az_c;
                mul_b = 32'(az_c);
            end
            4'd3:
            begin
                mul_a = sx2_reg[19:0];
                mul_b = sc2_reg;
            end
            4'd4:
            begin
                mul_a = 20'(sx2_reg[37:20]);
                mul_b = sc2_reg;
            end
            4'd5:
            begin
                mul_a = sz2_reg[19:0];
                mul_b = sc2_reg;
            end
            4'd6:
            begin
                mul_a = 20'(sz2_reg[37:20]);
                mul_b = sc2_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 52'(mul_a) * 52'(mul_b);

    // search for the largest k with l2 * (2k-1)^2 <= 2^30 * a^2
    always_comb
    begin
        unique case (comp_reg)
            COMP_X:  r_sel = $signed(WW'(xq_reg) << 30);
            COMP_Y:  r_sel = $signed(WW'(nsq) << 62);
            COMP_Z:  r_sel = $signed(WW'(zq_reg) << 30);
            default: r_sel = '0;
        endcase
    end

    assign cand = tmp_reg + ls_reg;
    assign acc  = (cand <= r_sel);
    assign k_c  = acc ? (m_reg | (NY_W'(1) << bit_reg)) : m_reg;

    assign out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);
    assign nx_c = (n_reg == '0) ? '0 :
                  (sx_reg[SUM_W-1] ? (NX_W'(0) - NX_W'(kx_reg)) : NX_W'(kx_reg));
    assign ny_c = (n_reg == '0) ? '0 : ky_reg;
    assign nz_c = (n_reg == '0) ? '0 :
                  (sz_reg[SUM_W-1] ? (NZ_W'(0) - NZ_W'(kz_reg)) : NZ_W'(kz_reg));

    // datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ && rd_cnt_reg != 4'd0)
        begin
            for (int i = 0; i < 8; i++)
                win_reg[i] <= win_reg[i+1];
            win_reg[8] <= SUM_W'($signed(rd_data_reg));
        end
        if (state_reg == ST_SUM)
        begin
            sx_reg <= sx_c;
            sz_reg <= sz_c;
            n_reg  <= n_c;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= mul_p;
            unique case (mul_step_reg)
                4'd1:    sc2_reg <= prod_reg[31:0];
                4'd2:    sx2_reg <= prod_reg[37:0];
                4'd3:    sz2_reg <= prod_reg[37:0];
                4'd4:    xq_reg  <= 70'(prod_reg);
                4'd5:    xq_reg  <= xq_reg + (70'(prod_reg) << 20);
                4'd6:    zq_reg  <= 70'(prod_reg);
                4'd7:    zq_reg  <= zq_reg + (70'(prod_reg) << 20);
                4'd8:    l2_reg  <= 72'(xq_reg) + 72'(zq_reg) + (72'(nsq) << 32);
                default: ;
            endcase
        end
        if (state_reg == ST_SEARCH_INIT)
        begin
            f_reg  <= $signed(WW'(l2_reg));
            g_reg  <= -($signed(WW'(l2_reg)) <<< 16);
            ls_reg <= $signed(WW'(l2_reg)) <<< 30;
            m_reg  <= '0;
        end
        if (state_reg == ST_SEARCH_ADD)
        begin
            tmp_reg  <= f_reg + g_reg;
            gacc_reg <= g_reg + (ls_reg <<< 1);
        end
        if (state_reg == ST_SEARCH_CMP)
        begin
            if (acc)
            begin
                f_reg <= cand;
                g_reg <= gacc_reg >>> 1;
            end
            else
                g_reg <= g_reg >>> 1;
            ls_reg <= ls_reg >>> 2;
            m_reg  <= k_c;
            if (bit_reg == 4'd0)
            begin
                unique case (comp_reg)
                    COMP_X:  kx_reg <= k_c;
                    COMP_Y:  ky_reg <= k_c;
                    COMP_Z:  kz_reg <= k_c;
                    default: ;
                endcase
            end
        end
        if (out_load)
            m_tdata_reg <= {5'b0, POS_OUT_W'(vc_reg), POS_OUT_W'(vr_reg), nz_c, ny_c, nx_c};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            grid_cols_reg    <= GRID_CFG_W'(1024);
            grid_rows_reg    <= GRID_CFG_W'(1024);
            height_scale_reg <= SCALE_W'(131);
            row_pos_reg      <= '0;
            col_pos_reg      <= '0;
            drain_pos_reg    <= '0;
            draining_reg     <= 1'b0;
            vr_reg           <= '0;
            vc_reg           <= '0;
            second_reg       <= 1'b0;
            last_reg         <= 1'b0;
            rd_cnt_reg       <= '0;
            ri_reg           <= '0;
            ci_reg           <= '0;
            mul_step_reg     <= '0;
            comp_reg         <= COMP_X;
            bit_reg          <= '0;
            m_tvalid_reg     <= 1'b0;
            m_tlast_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_GRID_COLS:    grid_cols_reg    <= cfg_data[GRID_CFG_W-1:0];
                    REG_GRID_ROWS:    grid_rows_reg    <= cfg_data[GRID_CFG_W-1:0];
                    REG_HEIGHT_SCALE: height_scale_reg <= cfg_data[SCALE_W-1:0];
                    default:          ;
                endcase
            end
            if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        if (s_tuser)
                        begin
                            if (draining_reg)
                            begin
                                vr_reg     <= PW'(rows_c - DW'(1));
                                vc_reg     <= drain_pos_reg;
                                last_reg   <= drain_end;
                                second_reg <= 1'b0;
                                if (drain_end)
                                begin
                                    draining_reg  <= 1'b0;
                                    drain_pos_reg <= '0;
                                end
                                else
                                    drain_pos_reg <= drain_pos_reg + PW'(1);
                                rd_cnt_reg <= '0;
                                ri_reg     <= '0;
                                ci_reg     <= '0;
                                state_reg  <= ST_READ;
                            end
                        end
                        else if (!draining_reg)
                        begin
                            if (col_end)
                            begin
                                col_pos_reg <= '0;
                                if (row_end)
                                begin
                                    row_pos_reg   <= '0;
                                    draining_reg  <= 1'b1;
                                    drain_pos_reg <= '0;
                                end
                                else
                                    row_pos_reg <= row_pos_reg + PW'(1);
                            end
                            else
                                col_pos_reg <= col_pos_reg + PW'(1);
                            if (row_pos_reg != '0 && (col_pos_reg != '0 || col_end))
                            begin
                                vr_reg     <= row_pos_reg - PW'(1);
                                vc_reg     <= (col_pos_reg != '0) ? col_pos_reg - PW'(1)
                                                                  : col_pos_reg;
                                second_reg <= (col_pos_reg != '0) && col_end;
                                last_reg   <= 1'b0;
                                rd_cnt_reg <= '0;
                                ri_reg     <= '0;
                                ci_reg     <= '0;
                                state_reg  <= ST_READ;
                            end
                        end
                    end
                end
                ST_READ:
                begin
                    rd_cnt_reg <= rd_cnt_reg + 4'd1;
                    if (ci_reg == 2'd2)
                    begin
                        ci_reg <= '0;
                        ri_reg <= ri_reg + 2'd1;
                    end
                    else
                        ci_reg <= ci_reg + 2'd1;
                    if (rd_cnt_reg == 4'd9)
                        state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    mul_step_reg <= '0;
                    state_reg    <= ST_MUL;
                end
                ST_MUL:
                begin
                    mul_step_reg <= mul_step_reg + 4'd1;
                    if (mul_step_reg == 4'd8)
                    begin
                        comp_reg  <= COMP_X;
                        state_reg <= (n_reg == '0) ? ST_OUT : ST_SEARCH_INIT;
                    end
                end
                ST_SEARCH_INIT:
                begin
                    bit_reg   <= 4'd14;
                    state_reg <= ST_SEARCH_ADD;
                end
                ST_SEARCH_ADD:
                    state_reg <= ST_SEARCH_CMP;
                ST_SEARCH_CMP:
                begin
                    if (bit_reg == 4'd0)
                    begin
                        if (comp_reg == COMP_Z)
                            state_reg <= ST_OUT;
                        else
                        begin
                            comp_reg  <= comp_reg + 2'd1;
                            state_reg <= ST_SEARCH_INIT;
                        end
                    end
                    else
                    begin
                        bit_reg   <= bit_reg - 4'd1;
                        state_reg <= ST_SEARCH_ADD;
                    end
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tlast_reg  <= last_reg;
                        if (second_reg)
                        begin
                            vc_reg     <= vc_reg + PW'(1);
                            second_reg <= 1'b0;
                            rd_cnt_reg <= '0;
                            ri_reg     <= '0;
                            ci_reg     <= '0;
                            state_reg  <= ST_READ;
                        end
                        else
                            state_reg <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/hvn_checker.sv
// port-level checks for the heightfield normal block, bound to the top level
`include "assert_macros.svh"

module hvn_checker
    import hvn_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // a held result keeps its payload
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // x and y unit components stay within one in q1.14
    `ASSERT_IMPLIES(a_ny_range, clk, rst_n, m_tvalid, m_tdata[30:16] <= NY_W'(UNIT_ONE))
    `ASSERT_IMPLIES(a_nx_range, clk, rst_n, m_tvalid, $signed(m_tdata[15:0]) >= -16'sd16384 && $signed(m_tdata[15:0]) <= 16'sd16384)

    // a new result only appears after a busy cycle
    `ASSERT_IMPLIES(a_out_after_busy, clk, rst_n, $rose(m_tvalid), !$past(s_tready))

endmodule

bind heightfield_vertex_normals hvn_checker u_hvn_checker (.*);

FILE: bench/heightfield_vertex_normals_tb.sv
// self-checking testbench for the heightfield vertex normal block
module heightfield_vertex_normals_tb;
    import hvn_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_MAX    = 1024;
    localparam int CYCLE_LIMIT = 20_000_000;
    localparam int DRAIN_PAUSE = 260;

    typedef enum logic { CMD_SAMPLE = 1'b0, CMD_DRAIN = 1'b1 } cmd_t;

    typedef struct packed {
        logic [NX_W-1:0]      nx;
        logic [NY_W-1:0]      ny;
        logic [NZ_W-1:0]      nz;
        logic [POS_OUT_W-1:0] row;
        logic [POS_OUT_W-1:0] col;
        logic                 last;
    } normal_t;

    class normal_scoreboard;
        logic [HEIGHT_W-1:0] heights [3*GRID_MAX];
        int unsigned row_pos, col_pos, drain_pos;
        bit draining;
        int unsigned cols_reg, rows_reg, scale_reg;
        normal_t normal_q [$];
        int errors;
        int mismatches;

        function new();
            foreach (heights[i]) heights[i] = '0;
            row_pos = 0;
            col_pos = 0;
            drain_pos = 0;
            draining = 0;
            cols_reg = 1024;
            rows_reg = 1024;
            scale_reg = 131;
            errors = 0;
            mismatches = 0;
        endfunction

        function int unsigned clamp_dim(int unsigned v);
            if (v < 2) return 2;
            if (v > GRID_MAX) return GRID_MAX;
            return v;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            if (idx == REG_GRID_COLS) cols_reg = d[GRID_CFG_W-1:0];
            else if (idx == REG_GRID_ROWS) rows_reg = d[GRID_CFG_W-1:0];
            else if (idx == REG_HEIGHT_SCALE) scale_reg = d;
        endfunction

        function longint height_at(longint r, longint c);
            if (r < 0 || c < 0 || c >= GRID_MAX) return 0;
            return longint'($signed(heights[(r % 3) * GRID_MAX + c]));
        endfunction

        // round(16384 * av / sqrt(l2)), ties away from zero
        function longint unit_mag(logic [127:0] av, logic [127:0] l2);
            logic [127:0] rhs;
            logic [127:0] t;
            longint lo, hi, mid;
            rhs = (av * av) << 30;
            lo = 0;
            hi = UNIT_ONE;
            while (lo < hi)
            begin
                mid = (lo + hi + 1) / 2;
                t = 128'(2 * mid - 1);
                if (l2 * t * t <= rhs) lo = mid;
                else hi = mid - 1;
            end
            return lo;
        endfunction

        function logic [15:0] signed_unit(longint s, logic [127:0] l2);
            longint k;
            k = unit_mag(128'(scale_reg) * 128'(s < 0 ? -s : s), l2);
            return (s < 0) ? 16'(-k) : 16'(k);
        endfunction

        function normal_t vertex_normal(longint vr, longint vc, int unsigned rows,
                                        int unsigned cols, bit last);
            normal_t o;
            longint sx, sz, n, cr, cc, ha, hb, hc, hd;
            logic [127:0] ax, ay, az, l2;
            sx = 0;
            sz = 0;
            n = 0;
            for (int dr = -1; dr <= 0; dr++)
            begin
                for (int dc = -1; dc <= 0; dc++)
                begin
                    cr = vr + dr;
                    cc = vc + dc;
                    if (cr < 0 || cc < 0 || cr > longint'(rows) - 2 || cc > longint'(cols) - 2)
                        continue;
                    ha = height_at(cr, cc);
                    hb = height_at(cr, cc + 1);
                    hc = height_at(cr + 1, cc + 1);
                    hd = height_at(cr + 1, cc);
                    if (dc == 0 && dr == 0 || dc == -1 && dr == -1)
                    begin
                        sx += (ha - hb) + (hd - hc);
                        sz += (hc - hb) + (hd - ha);
                        n += 2;
                    end
                    else if (dr == 0)
                    begin
                        sx += ha - hb;
                        sz += hc - hb;
                        n += 1;
                    end
                    else
                    begin
                        sx += hd - hc;
                        sz += hd - ha;
                        n += 1;
                    end
                end
            end
            if (n == 0)
            begin
                o.nx = '0;
                o.ny = '0;
                o.nz = '0;
            end
            else
            begin
                ax = 128'(scale_reg) * 128'(sx < 0 ? -sx : sx);
                az = 128'(scale_reg) * 128'(sz < 0 ? -sz : sz);
                ay = 128'(65536) * 128'(n);
                l2 = ax * ax + ay * ay + az * az;
                o.nx = signed_unit(sx, l2);
                o.ny = 15'(unit_mag(ay, l2));
                o.nz = signed_unit(sz, l2);
            end
            o.row = 10'(vr);
            o.col = 10'(vc);
            o.last = last;
            return o;
        endfunction

        function void take_item(cmd_t cmd, logic [HEIGHT_W-1:0] h);
            int unsigned cols, rows, r, c;
            cols = clamp_dim(cols_reg);
            rows = clamp_dim(rows_reg);
            if (cmd == CMD_DRAIN)
            begin
                if (!draining) return;
                normal_q.push_back(vertex_normal(rows - 1, drain_pos, rows, cols,
                                                 drain_pos + 1 >= cols));
                drain_pos++;
                if (drain_pos >= cols)
                begin
                    draining = 0;
                    drain_pos = 0;
                end
                return;
            end
            if (draining) return;
            r = row_pos;
            c = col_pos;
            if (c < GRID_MAX) heights[(r % 3) * GRID_MAX + c] = h;
            if (r >= 1)
            begin
                if (c >= 1) normal_q.push_back(vertex_normal(r - 1, c - 1, rows, cols, 0));
                if (c + 1 >= cols) normal_q.push_back(vertex_normal(r - 1, c, rows, cols, 0));
            end
            if (c + 1 >= cols)
            begin
                col_pos = 0;
                if (r + 1 >= rows)
                begin
                    row_pos = 0;
                    draining = 1;
                    drain_pos = 0;
                end
                else row_pos = r + 1;
            end
            else col_pos = c + 1;
        endfunction

        function void check_normal(logic [OUT_DATA_W-1:0] d, logic last);
            normal_t want, got;
            got.nx = d[15:0];
            got.ny = d[30:16];
            got.nz = d[46:31];
            got.row = d[56:47];
            got.col = d[66:57];
            got.last = last;
            if (normal_q.size() == 0)
            begin
                errors++;
                if (mismatches++ < 10)
                    $display("unexpected normal row %0d col %0d", got.row, got.col);
                return;
            end
            want = normal_q.pop_front();
            if (got != want)
            begin
                errors++;
                if (mismatches++ < 10)
                    $display({"normal mismatch exp x %0d y %0d z %0d r %0d c %0d l %0d,",
                              " got x %0d y %0d z %0d r %0d c %0d l %0d"},
                             $signed(want.nx), want.ny, $signed(want.nz), want.row, want.col,
                             want.last, $signed(got.nx), got.ny, $signed(got.nz), got.row,
                             got.col, got.last);
            end
        endfunction

        function int pending();
            return normal_q.size();
        endfunction
    endclass

    logic                  clk = 0;
    logic                  rst_n = 0;
    logic                  s_tvalid = 0;
    logic                  s_tready;
    logic [HEIGHT_W-1:0]   s_tdata = '0;
    logic                  s_tuser = 0;
    logic                  m_tvalid;
    logic                  m_tready = 0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    normal_scoreboard sb = new();
    bit burst = 0;
    bit no_stall = 0;
    int stall_left = 0;
    int cycles = 0;
    int random_items = 0;

    heightfield_vertex_normals DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // output side backpressure
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 0;
        end
        else if (!no_stall && $urandom_range(0, 99) < 25)
        begin
            stall_left = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 3)
                                                      : $urandom_range(20, 150);
            m_tready <= 0;
        end
        else m_tready <= 1;
    end

    always @(negedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) sb.check_normal(m_tdata, m_tlast);
    end

    function int pick_gap();
        int r;
        if (burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 120);
    endfunction

    task send_item(cmd_t cmd, logic [HEIGHT_W-1:0] h);
        int gap;
        bit taken;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser <= cmd;
        s_tdata <= h;
        do
        begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end
        while (!taken);
        sb.take_item(cmd, h);
    endtask

    // hold off until every normal is out and the engine has gone quiet
    task settle();
        s_tvalid <= 0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        bit taken;
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= d;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        sb.set_reg(idx, d);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    function logic [HEIGHT_W-1:0] pick_height(int mode, logic [HEIGHT_W-1:0] prev);
        int r;
        case (mode)
            0: return 16'($urandom);
            1: return prev + 16'($signed($urandom_range(0, 64)) - 32);
            default:
            begin
                r = $urandom_range(0, 3);
                if (r == 0) return 16'h8000;
                if (r == 1) return 16'h7fff;
                return 16'($urandom);
            end
        endcase
    endfunction

    task run_frame(int cols, int rows, int mode, int noise_pct);
        logic [HEIGHT_W-1:0] h;
        h = 16'($urandom);
        for (int i = 0; i < cols * rows; i++)
        begin
            if ($urandom_range(0, 99) < noise_pct) send_item(CMD_DRAIN, 16'($urandom));
            h = pick_height(mode, h);
            send_item(CMD_SAMPLE, h);
            random_items++;
        end
        for (int i = 0; i < cols; i++)
        begin
            if ($urandom_range(0, 99) < noise_pct) send_item(CMD_SAMPLE, 16'($urandom));
            send_item(CMD_DRAIN, 16'($urandom));
            random_items++;
        end
    endtask

    initial
    begin
        int cols, rows, pick;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // smallest grid through clamping, steepest faces at full scale
        write_reg(REG_GRID_COLS, 16'd1);
        write_reg(REG_GRID_ROWS, 16'd0);
        write_reg(REG_HEIGHT_SCALE, 16'hffff);
        send_item(CMD_DRAIN, 16'h0000);
        send_item(CMD_SAMPLE, 16'h8000);
        send_item(CMD_SAMPLE, 16'h7fff);
        send_item(CMD_SAMPLE, 16'h7fff);
        send_item(CMD_SAMPLE, 16'h8000);
        send_item(CMD_SAMPLE, 16'h1234);
        send_item(CMD_DRAIN, 16'hffff);
        send_item(CMD_DRAIN, 16'h0000);
        settle();

        // zero scale gives straight-up normals
        write_reg(REG_GRID_COLS, 16'd3);
        write_reg(REG_GRID_ROWS, 16'd3);
        write_reg(REG_HEIGHT_SCALE, 16'd0);
        run_frame(3, 3, 2, 0);
        settle();

        // rows shrunk mid-frame: the vertices of the next row have no adjacent cell
        write_reg(REG_GRID_COLS, 16'd4);
        write_reg(REG_GRID_ROWS, 16'd6);
        write_reg(REG_HEIGHT_SCALE, 16'd1000);
        for (int i = 0; i < 16; i++) send_item(CMD_SAMPLE, 16'($urandom));
        settle();
        write_reg(REG_GRID_ROWS, 16'd2);
        for (int i = 0; i < 4; i++) send_item(CMD_SAMPLE, 16'($urandom));
        for (int i = 0; i < 4; i++) send_item(CMD_DRAIN, 16'h0000);
        settle();

        // first row at the widest clamped size without gaps, then the columns shrunk
        write_reg(REG_GRID_COLS, 16'h07ff);
        write_reg(REG_GRID_ROWS, 16'd2);
        write_reg(REG_HEIGHT_SCALE, 16'd131);
        burst = 1;
        no_stall = 1;
        for (int i = 0; i < GRID_MAX; i++) send_item(CMD_SAMPLE, 16'($urandom));
        settle();
        write_reg(REG_GRID_COLS, 16'd4);
        for (int i = 0; i < 4; i++) send_item(CMD_SAMPLE, 16'($urandom));
        for (int i = 0; i < 4; i++) send_item(CMD_DRAIN, 16'h0000);
        burst = 0;
        no_stall = 0;
        settle();

        random_items = 0;
        while (random_items < 370)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                settle();
                pick = $urandom_range(0, 9);
                cols = (pick == 0) ? $urandom_range(13, 40) : $urandom_range(2, 12);
                rows = (pick == 1) ? $urandom_range(9, 20) : $urandom_range(2, 8);
                write_reg(REG_GRID_COLS, 16'(cols));
                write_reg(REG_GRID_ROWS, 16'(rows));
                pick = $urandom_range(0, 5);
                write_reg(REG_HEIGHT_SCALE, pick == 0 ? 16'd0 : pick == 1 ? 16'hffff
                                                      : 16'($urandom));
            end
            else
            begin
                cols = sb.clamp_dim(sb.cols_reg);
                rows = sb.clamp_dim(sb.rows_reg);
            end
            burst = ($urandom_range(0, 5) == 0);
            no_stall = ($urandom_range(0, 5) == 0);
            run_frame(cols, rows, $urandom_range(0, 2), 5);
            if ($urandom_range(0, 2) == 0) settle();
        end
        burst = 0;
        no_stall = 0;

        settle();
        if (sb.pending() != 0) sb.errors++;
        if (sb.errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: heightfield_vertex_normals.f
+incdir+rtl
rtl/hvn_pkg.sv
rtl/heightfield_vertex_normals.sv
rtl/hvn_checker.sv
bench/heightfield_vertex_normals_tb.sv
